// ===== src/scr_pkg.sv =====
package scr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = 20;
  localparam int GAP_W    = 7;

  localparam logic [GAP_W-1:0] GAP_RESET = 7'd55;

  localparam int NUM_ECHOES_DEF  = 24;
  localparam int MAX_GAP_DEF     = 64;
  localparam int STORE_DEPTH_DEF = 32768;

  localparam int DECAY_DIV = 10;

  // Reciprocal scaling shared by both constant divisions.
  localparam int RECIP_K = 25;
  localparam int CMUL_W  = 26;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] right;
    logic signed [ENTRY_W-1:0] left;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_RDA   = 5'b00100,
    S_WRA   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

endpackage

// ===== src/stereo_comb_reverb_unit.sv =====
// Stereo feedback comb reverb, one input item in, one result item out.
// No new input item is taken until the last one is through; the pace is set by
// the single echo store, which sees two read-modify-write accesses per ring.
// Reset (rst_n low, synchronous) and every cfg write start a clearing pass that
// zeroes all STORE_DEPTH store entries; no input item is taken during it.
module stereo_comb_reverb_unit #(
  parameter int NUM_ECHOES  = scr_pkg::NUM_ECHOES_DEF,
  parameter int MAX_GAP     = scr_pkg::MAX_GAP_DEF,
  parameter int STORE_DEPTH = scr_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input item: left_in [15:0], right_in [31:16].
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,
  // Result item: left_wet [15:0], right_wet [31:16].
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  // Configuration: sample_gap.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scr_pkg::GAP_W-1:0]  cfg_data
);
  import scr_pkg::*;

  // Sizes that follow from the parameters.
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int MAXLEN  = (MAX_GAP + 2 * NUM_ECHOES) * NUM_ECHOES;
  localparam int LEN_W   = $clog2(MAXLEN + 1);
  localparam int IDX_W   = (NUM_ECHOES > 1) ? $clog2(NUM_ECHOES) : 1;
  localparam int STEP_W  = $clog2(MAX_GAP + 4 * NUM_ECHOES + 3);
  localparam int PROD_W  = ENTRY_W + CMUL_W;

  // Reciprocals: floor(m * C / 2^RECIP_K) equals m / d for every 20-bit magnitude.
  localparam logic [CMUL_W-1:0] C_DECAY =
    CMUL_W'(((1 << RECIP_K) + DECAY_DIV - 1) / DECAY_DIV);
  localparam logic [CMUL_W-1:0] C_ECHO  =
    CMUL_W'(((1 << RECIP_K) + NUM_ECHOES - 1) / NUM_ECHOES);

  localparam logic [ADDR_W:0]  DEPTH_X = (ADDR_W+1)'(STORE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(NUM_ECHOES - 1);

  // Signed division truncated toward zero, by a reciprocal multiply.
  function automatic logic signed [ENTRY_W-1:0] div_tz(
    input logic signed [ENTRY_W-1:0] v,
    input logic [CMUL_W-1:0]         c
  );
    logic [ENTRY_W-1:0] mag;
    logic [PROD_W-1:0]  prod;
    logic [ENTRY_W-1:0] q;
    mag  = v[ENTRY_W-1] ? ENTRY_W'(-v) : ENTRY_W'(v);
    prod = PROD_W'(mag) * PROD_W'(c);
    q    = prod[RECIP_K +: ENTRY_W];
    return v[ENTRY_W-1] ? $signed(-q) : $signed(q);
  endfunction

  // Control state.
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r;
  logic [GAP_W-1:0]   gap_r;
  logic [IDX_W-1:0]   k_r;
  logic               out_tvalid_r;
  logic [31:0]        out_tdata_r;

  // Per-ring positions. A fresh ring sits at its base entry with position zero.
  logic [LEN_W-1:0]   pos_r   [NUM_ECHOES];
  logic [ADDR_W-1:0]  raddr_r [NUM_ECHOES];
  logic [NUM_ECHOES-1:0] fresh_r;

  // Geometry of the ring under work, kept as running sums.
  logic [LEN_W-1:0]   len_r;
  logic [ADDR_W-1:0]  len_mod_r;
  logic [ADDR_W-1:0]  base_mod_r;

  // Item payload and accumulators.
  logic signed [SAMPLE_W-1:0] xl_r, xr_r;
  logic [SAMPLE_W-1:0]        acc_lt_r, acc_rt_r;
  logic [ADDR_W-1:0]          a_addr_r;
  logic [ADDR_W-1:0]          wb_addr_r;

  // Echo store with a registered read port and write forwarding.
  entry_t             echo_store_r [STORE_DEPTH];
  entry_t             rd_q_r;
  entry_t             fwd_d_r;
  logic               fwd_r;
  entry_t             rd_eff;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_wa, mem_ra;
  entry_t             mem_wd;

  logic               in_acc, cfg_acc;
  logic [LEN_W-1:0]   g_sat;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W-1:0]  a_cur;
  logic [ADDR_W:0]    a_inc;
  logic [ADDR_W-1:0]  b_addr;
  logic [LEN_W:0]     pos_inc;
  logic               pos_wrap;
  logic [ADDR_W:0]    len_mod_sum, base_sum;
  entry_t             decayed;
  logic [SAMPLE_W-1:0] acc_lt_nxt, acc_rt_nxt;

  // A pending gap write takes precedence, so the input is held off meanwhile.
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The gap is held inside 1..MAX_GAP when ring lengths are formed.
  always_comb begin
    if (gap_r == '0) begin
      g_sat = LEN_W'(1);
    end else if (32'(gap_r) > MAX_GAP) begin
      g_sat = LEN_W'(MAX_GAP);
    end else begin
      g_sat = LEN_W'(gap_r);
    end
  end

  // Ring n+1 is longer than ring n by gap + 4n + 2, with n = k + 1.
  assign step = STEP_W'(g_sat) + STEP_W'({k_r, 2'b00}) + STEP_W'(6);

  assign len_mod_sum = (ADDR_W+1)'(len_mod_r) + (ADDR_W+1)'(step);
  assign base_sum    = (ADDR_W+1)'(base_mod_r) + (ADDR_W+1)'(len_mod_r);

  // Entry under the ring position, and the one after the advance.
  assign a_cur    = fresh_r[k_r] ? base_mod_r : raddr_r[k_r];
  assign pos_inc  = (LEN_W+1)'(pos_r[k_r]) + (LEN_W+1)'(1);
  assign pos_wrap = (pos_inc >= (LEN_W+1)'(len_r));
  assign a_inc    = (ADDR_W+1)'(a_addr_r) + (ADDR_W+1)'(1);
  assign b_addr   = pos_wrap ? base_mod_r :
                    ((a_inc == DEPTH_X) ? '0 : a_inc[ADDR_W-1:0]);

  assign rd_eff = fwd_r ? fwd_d_r : rd_q_r;

  // The read value loses a tenth and contributes its share to the wet sum.
  always_comb begin
    decayed.left  = rd_eff.left  - div_tz(rd_eff.left,  C_DECAY);
    decayed.right = rd_eff.right - div_tz(rd_eff.right, C_DECAY);
    acc_lt_nxt    = acc_lt_r + SAMPLE_W'(div_tz(rd_eff.left,  C_ECHO));
    acc_rt_nxt    = acc_rt_r + SAMPLE_W'(div_tz(rd_eff.right, C_ECHO));
  end

  // Store port selection. Each ring takes a read and a write state: S_RDA writes back the
  // previous ring's read entry while it reads this ring's current entry, S_WRA
  // writes the sum into the current entry while it reads the next one.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wb_addr_r;
    mem_wd = decayed;
    mem_re = 1'b0;
    mem_ra = a_cur;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      S_RDA: begin
        mem_we = (k_r != '0);
        mem_re = 1'b1;
      end
      S_WRA: begin
        mem_we      = 1'b1;
        mem_wa      = a_addr_r;
        mem_wd.left  = rd_eff.left  + ENTRY_W'(xl_r);
        mem_wd.right = rd_eff.right + ENTRY_W'(xr_r);
        mem_re      = 1'b1;
        mem_ra      = b_addr;
      end
      S_FIN: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      echo_store_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r  <= echo_store_r[mem_ra];
      fwd_r   <= mem_we && (mem_wa == mem_ra);
      fwd_d_r <= mem_wd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          state_nxt = S_CLEAR;
        end else if (in_acc) begin
          state_nxt = S_RDA;
        end
      end
      S_CLEAR: begin
        if (!cfg_acc && (clr_r == ADDR_W'(STORE_DEPTH - 1))) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDA: begin
        state_nxt = S_WRA;
      end
      S_WRA: begin
        state_nxt = (k_r == LAST_K) ? S_FIN : S_RDA;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      gap_r        <= GAP_RESET;
      fresh_r      <= '1;
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
      for (int i = 0; i < NUM_ECHOES; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Hold the last write back until the output register is free.
      if ((state_r == S_FIN) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (cfg_acc) begin
        // A new gap restarts every ring and the clearing pass.
        gap_r   <= cfg_data;
        clr_r   <= '0;
        fresh_r <= '1;
        for (int i = 0; i < NUM_ECHOES; i++) begin
          pos_r[i] <= '0;
        end
      end else begin
        case (state_r)
          S_IDLE: begin
            if (in_acc) begin
              k_r <= '0;
            end
          end
          S_CLEAR: begin
            clr_r <= clr_r + ADDR_W'(1);
          end
          S_WRA: begin
            // Advance the ring and move on to the next one.
            pos_r[k_r]   <= pos_wrap ? '0 : pos_inc[LEN_W-1:0];
            raddr_r[k_r] <= b_addr;
            fresh_r[k_r] <= 1'b0;
            k_r          <= k_r + IDX_W'(1);
          end
          default: begin
            k_r <= k_r;
          end
        endcase
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        xl_r       <= $signed(in_tdata[15:0]);
        xr_r       <= $signed(in_tdata[31:16]);
        acc_lt_r   <= '0;
        acc_rt_r   <= '0;
        len_r      <= g_sat + LEN_W'(2);
        len_mod_r  <= ADDR_W'(g_sat) + ADDR_W'(2);
        base_mod_r <= '0;
      end
      S_RDA: begin
        a_addr_r <= a_cur;
        if (k_r != '0) begin
          acc_lt_r <= acc_lt_nxt;
          acc_rt_r <= acc_rt_nxt;
        end
      end
      S_WRA: begin
        wb_addr_r  <= b_addr;
        len_r      <= len_r + LEN_W'(step);
        len_mod_r  <= (len_mod_sum >= DEPTH_X) ? ADDR_W'(len_mod_sum - DEPTH_X)
                                               : len_mod_sum[ADDR_W-1:0];
        base_mod_r <= (base_sum >= DEPTH_X) ? ADDR_W'(base_sum - DEPTH_X)
                                            : base_sum[ADDR_W-1:0];
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {acc_rt_nxt, acc_lt_nxt};
        end
      end
      default: begin
        a_addr_r <= a_addr_r;
      end
    endcase
  end

endmodule
